/* sv/hrlud_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrlud_pkg: shared types and constants of the request-line URL decoder
// Kind codes, controller/datapath command and status groups, store sizing.
// ----------------------------------------------------------------------------
package hrlud_pkg;

    localparam int URL_DEPTH  = 64;
    localparam int ADDR_W     = $clog2(URL_DEPTH);
    localparam int LEN_W      = $clog2(URL_DEPTH + 1);
    localparam int BROKEN_LEN = 9;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_QUEST   = 8'h3F;

    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_URL     = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_EOL     = 3'd4
    } kind_t;

    typedef struct packed {
        logic  url_byte_en;
        logic  run_start;
        logic  rd_en;
        logic  load_pass;
        kind_t pass_kind;
        logic  load_run;
        logic  load_empty;
        logic  load_eol;
        logic  clear;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic run_empty;
        logic run_last;
    } dp_status_t;

endpackage
`default_nettype wire

/* sv/hrlud_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrlud_datapath: percent decoder, URL store and result register
// Decodes URL bytes into the store, tracks dot and question mark flags,
// and drives the output item register under controller command.
// ----------------------------------------------------------------------------
module hrlud_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hrlud_pkg::dp_cmd_t  cmd,
    output hrlud_pkg::dp_status_t    status,
    input  wire logic [7:0]          in_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_kind,
    output logic [7:0]               m_out_byte,
    output logic                     m_last_of_url,
    output logic                     m_broken,
    output logic                     m_overflow
);
    import hrlud_pkg::*;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_FIRST = 2'd1,
        ESC_SECOND = 2'd2
    } esc_t;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] broken_char(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = 8'h62;
            4'd1:    r = 8'h72;
            4'd2:    r = 8'h6F;
            4'd3:    r = 8'h6B;
            4'd4:    r = 8'h65;
            4'd5:    r = 8'h6E;
            4'd6:    r = 8'h55;
            4'd7:    r = 8'h52;
            4'd8:    r = 8'h4C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    logic [7:0]       url_store [URL_DEPTH];
    logic [7:0]       rd_data_reg;

    esc_t             esc_reg, esc_next;
    logic [3:0]       nib_reg, nib_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             qseen_reg, qseen_next;
    logic [LEN_W-1:0] qidx_reg, qidx_next;
    logic             dot_reg, dot_next;
    logic             dotdot_reg, dotdot_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic [LEN_W-1:0] run_idx_reg, run_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             broken_reg, broken_next;
    logic             ovfo_reg, ovfo_next;

    logic             append;
    logic [7:0]       dec_byte;
    logic             wr_en;
    logic [4:0]       hex;
    logic [LEN_W-1:0] cut_len;

    assign hex = hex_decode(in_byte);
    assign cut_len = qseen_reg ? qidx_reg : len_reg;

    always_comb begin
        esc_next     = esc_reg;
        nib_next     = nib_reg;
        len_next     = len_reg;
        qseen_next   = qseen_reg;
        qidx_next    = qidx_reg;
        dot_next     = dot_reg;
        dotdot_next  = dotdot_reg;
        ovf_next     = ovf_reg;
        run_len_next = run_len_reg;
        run_idx_next = run_idx_reg;
        append       = 1'b0;
        dec_byte     = in_byte;
        wr_en        = 1'b0;

        if (cmd.url_byte_en) begin
            unique case (esc_reg)
                ESC_NONE: begin
                    if (in_byte == CHAR_PERCENT) begin
                        esc_next = ESC_FIRST;
                        nib_next = 4'd0;
                    end else begin
                        append = 1'b1;
                    end
                end
                ESC_FIRST: begin
                    nib_next = hex[4] ? hex[3:0] : 4'd0;
                    esc_next = ESC_SECOND;
                end
                default: begin
                    dec_byte = {nib_reg, hex[4] ? hex[3:0] : nib_reg};
                    append   = 1'b1;
                    esc_next = ESC_NONE;
                    nib_next = 4'd0;
                end
            endcase
        end

        if (append) begin
            if (dec_byte == CHAR_DOT) begin
                if (dot_reg) begin
                    dotdot_next = 1'b1;
                end
                dot_next = 1'b1;
            end else begin
                dot_next = 1'b0;
            end
            if (dec_byte == CHAR_QUEST && !qseen_reg) begin
                qseen_next = 1'b1;
                qidx_next  = len_reg;
            end
            if (len_reg < LEN_W'(URL_DEPTH)) begin
                wr_en    = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.run_start) begin
            esc_next     = ESC_NONE;
            nib_next     = 4'd0;
            run_len_next = dotdot_reg ? LEN_W'(BROKEN_LEN) : cut_len;
            run_idx_next = '0;
        end

        if (cmd.load_run) begin
            run_idx_next = run_idx_reg + LEN_W'(1);
        end

        if (cmd.clear) begin
            esc_next    = ESC_NONE;
            nib_next    = 4'd0;
            len_next    = '0;
            qseen_next  = 1'b0;
            qidx_next   = '0;
            dot_next    = 1'b0;
            dotdot_next = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    assign status.out_free  = !out_valid_reg || m_ready;
    assign status.run_empty = (run_len_reg == '0);
    assign status.run_last  = ((run_idx_reg + LEN_W'(1)) == run_len_reg);

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        broken_next    = broken_reg;
        ovfo_next      = ovfo_reg;
        if (cmd.load_pass) begin
            out_valid_next = 1'b1;
            kind_next      = cmd.pass_kind;
            byte_next      = in_byte;
            last_next      = 1'b0;
            broken_next    = 1'b0;
            ovfo_next      = 1'b0;
        end else if (cmd.load_run) begin
            out_valid_next = 1'b1;
            kind_next      = KIND_URL;
            byte_next      = dotdot_reg ? broken_char(run_idx_reg[3:0]) : rd_data_reg;
            last_next      = status.run_last;
            broken_next    = dotdot_reg;
            ovfo_next      = ovf_reg;
        end else if (cmd.load_empty) begin
            out_valid_next = 1'b1;
            kind_next      = KIND_EMPTY;
            byte_next      = 8'd0;
            last_next      = 1'b1;
            broken_next    = 1'b0;
            ovfo_next      = ovf_reg;
        end else if (cmd.load_eol) begin
            out_valid_next = 1'b1;
            kind_next      = KIND_EOL;
            byte_next      = 8'd0;
            last_next      = 1'b0;
            broken_next    = 1'b0;
            ovfo_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            url_store[len_reg[ADDR_W-1:0]] <= dec_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= url_store[run_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg       <= ESC_NONE;
            nib_reg       <= 4'd0;
            len_reg       <= '0;
            qseen_reg     <= 1'b0;
            qidx_reg      <= '0;
            dot_reg       <= 1'b0;
            dotdot_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            run_len_reg   <= '0;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            esc_reg       <= esc_next;
            nib_reg       <= nib_next;
            len_reg       <= len_next;
            qseen_reg     <= qseen_next;
            qidx_reg      <= qidx_next;
            dot_reg       <= dot_next;
            dotdot_reg    <= dotdot_next;
            ovf_reg       <= ovf_next;
            run_len_reg   <= run_len_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        broken_reg <= broken_next;
        ovfo_reg   <= ovfo_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = kind_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_url = last_reg;
    assign m_broken      = broken_reg;
    assign m_overflow    = ovfo_reg;

endmodule
`default_nettype wire

/* sv/hrlud_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hrlud_ctrl: request-line phase controller
// Tracks method, URL and version phases and sequences the URL run.
// ----------------------------------------------------------------------------
module hrlud_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             in_byte,
    output hrlud_pkg::dp_cmd_t          cmd,
    input  wire hrlud_pkg::dp_status_t  status
);
    import hrlud_pkg::*;

    typedef enum logic [2:0] {
        ST_METHOD  = 3'd0,
        ST_URL     = 3'd1,
        ST_VERSION = 3'd2,
        ST_RUN_RD  = 3'd3,
        ST_RUN_OUT = 3'd4
    } state_t;

    state_t state_reg, state_next;
    logic   fire;

    always_comb begin
        unique case (state_reg)
            ST_METHOD, ST_VERSION: s_ready = status.out_free;
            ST_URL:                s_ready = 1'b1;
            default:               s_ready = 1'b0;
        endcase
    end

    assign fire = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.pass_kind = KIND_METHOD;
        unique case (state_reg)
            ST_METHOD: begin
                if (fire) begin
                    if (in_byte == CHAR_SPACE) begin
                        state_next = ST_URL;
                    end else begin
                        cmd.load_pass = 1'b1;
                    end
                end
            end
            ST_URL: begin
                if (fire) begin
                    if (in_byte == CHAR_SPACE) begin
                        cmd.run_start = 1'b1;
                        state_next    = ST_RUN_RD;
                    end else begin
                        cmd.url_byte_en = 1'b1;
                    end
                end
            end
            ST_RUN_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RUN_OUT;
            end
            ST_RUN_OUT: begin
                if (status.out_free) begin
                    if (status.run_empty) begin
                        cmd.load_empty = 1'b1;
                        state_next     = ST_VERSION;
                    end else begin
                        cmd.load_run = 1'b1;
                        state_next   = status.run_last ? ST_VERSION : ST_RUN_RD;
                    end
                end
            end
            default: begin
                cmd.pass_kind = KIND_VERSION;
                if (fire) begin
                    if (in_byte == CHAR_NL) begin
                        cmd.load_eol = 1'b1;
                        cmd.clear    = 1'b1;
                        state_next   = ST_METHOD;
                    end else begin
                        cmd.load_pass = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_METHOD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* sv/http_request_line_url_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_line_url_decoder_core: request-line splitter with URL decoding
// Passes method and version bytes, percent-decodes the URL into a store and
// emits it as one run at the second space (up to any ?, or brokenURL after ..).
//
//   channel | ports                                   | role
//   s_      | s_valid s_ready s_in_byte               | raw request bytes
//   m_      | m_valid m_ready m_kind m_out_byte       | result items
//           | m_last_of_url m_broken m_overflow       |
//
// Method, URL and version bytes are taken while the output register drains.
// Each URL run item is a store read, then an output load that waits for a
// free output; an empty path gives one item. Input is held off meanwhile.
// Reset is synchronous, active low; the store needs no clearing pass.
// A stalled output blocks method and version bytes but not URL bytes.
// ----------------------------------------------------------------------------
module http_request_line_url_decoder_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_url,
    output logic            m_broken,
    output logic            m_overflow
);
    import hrlud_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hrlud_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_byte (s_in_byte),
        .cmd     (cmd),
        .status  (status)
    );

    hrlud_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_byte       (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_last_of_url (m_last_of_url),
        .m_broken      (m_broken),
        .m_overflow    (m_overflow)
    );

endmodule
`default_nettype wire
